// ===== rtl/ttint_pkg.sv =====
// Package for the thermistor table interpolator: field widths, register
// indexes, the breakpoint ROM and the divider request and response types.
// It depends on nothing else.
package ttint_pkg;

  localparam int ROM_ROWS          = 39;
  localparam int TABLE_ENTRIES_DEF = 39;
  localparam int CODE_W            = 10;
  localparam int TEMP_W            = 12;
  localparam int DEG_W             = 9;
  localparam int CLASS_W           = 2;
  localparam int IDX_W             = 6;
  localparam int NUM_W             = 16;
  localparam int DEN_W             = CODE_W;
  localparam int CFG_IDX_W         = 1;
  localparam int STEP_TENTHS       = 50;
  localparam int DEG_SCALE         = 10;
  localparam int COLD_RESET        = 250;
  localparam int HOT_RESET         = 300;

  localparam logic [CFG_IDX_W-1:0] REG_COLD_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_LIMIT  = 1'b1;

  localparam logic [CLASS_W-1:0] CLASS_COLD   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_NORMAL = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_HOT    = 2'd2;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [DEG_W-1:0] rom_deg(input logic [IDX_W-1:0] idx);
    logic signed [DEG_W-1:0] d;
    case (idx)
      6'd0:    d = -9'sd40;
      6'd1:    d = -9'sd35;
      6'd2:    d = -9'sd30;
      6'd3:    d = -9'sd25;
      6'd4:    d = -9'sd20;
      6'd5:    d = -9'sd15;
      6'd6:    d = -9'sd10;
      6'd7:    d = -9'sd5;
      6'd8:    d = 9'sd0;
      6'd9:    d = 9'sd5;
      6'd10:   d = 9'sd10;
      6'd11:   d = 9'sd15;
      6'd12:   d = 9'sd20;
      6'd13:   d = 9'sd25;
      6'd14:   d = 9'sd30;
      6'd15:   d = 9'sd35;
      6'd16:   d = 9'sd40;
      6'd17:   d = 9'sd45;
      6'd18:   d = 9'sd50;
      6'd19:   d = 9'sd55;
      6'd20:   d = 9'sd60;
      6'd21:   d = 9'sd65;
      6'd22:   d = 9'sd70;
      6'd23:   d = 9'sd75;
      6'd24:   d = 9'sd80;
      6'd25:   d = 9'sd85;
      6'd26:   d = 9'sd90;
      6'd27:   d = 9'sd95;
      6'd28:   d = 9'sd100;
      6'd29:   d = 9'sd105;
      6'd30:   d = 9'sd110;
      6'd31:   d = 9'sd115;
      6'd32:   d = 9'sd120;
      6'd33:   d = 9'sd125;
      6'd34:   d = 9'sd130;
      6'd35:   d = 9'sd135;
      6'd36:   d = 9'sd140;
      6'd37:   d = 9'sd145;
      6'd38:   d = 9'sd150;
      default: d = 9'sd0;
    endcase
    return d;
  endfunction

  function automatic logic [CODE_W-1:0] rom_adc(input logic [IDX_W-1:0] idx);
    logic [CODE_W-1:0] a;
    case (idx)
      6'd0:    a = 10'd30;
      6'd1:    a = 10'd41;
      6'd2:    a = 10'd55;
      6'd3:    a = 10'd73;
      6'd4:    a = 10'd96;
      6'd5:    a = 10'd124;
      6'd6:    a = 10'd157;
      6'd7:    a = 10'd196;
      6'd8:    a = 10'd240;
      6'd9:    a = 10'd289;
      6'd10:   a = 10'd342;
      6'd11:   a = 10'd398;
      6'd12:   a = 10'd455;
      6'd13:   a = 10'd512;
      6'd14:   a = 10'd566;
      6'd15:   a = 10'd619;
      6'd16:   a = 10'd667;
      6'd17:   a = 10'd712;
      6'd18:   a = 10'd752;
      6'd19:   a = 10'd788;
      6'd20:   a = 10'd819;
      6'd21:   a = 10'd847;
      6'd22:   a = 10'd870;
      6'd23:   a = 10'd891;
      6'd24:   a = 10'd909;
      6'd25:   a = 10'd924;
      6'd26:   a = 10'd937;
      6'd27:   a = 10'd948;
      6'd28:   a = 10'd958;
      6'd29:   a = 10'd966;
      6'd30:   a = 10'd974;
      6'd31:   a = 10'd980;
      6'd32:   a = 10'd985;
      6'd33:   a = 10'd989;
      6'd34:   a = 10'd993;
      6'd35:   a = 10'd997;
      6'd36:   a = 10'd1000;
      6'd37:   a = 10'd1002;
      6'd38:   a = 10'd1005;
      default: a = 10'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [TEMP_W-1:0] rom_tenths(input logic [IDX_W-1:0] idx);
    logic signed [TEMP_W-1:0] d;
    d = TEMP_W'(rom_deg(idx));
    return d * TEMP_W'(DEG_SCALE);
  endfunction

endpackage

// ===== rtl/ttint_div.sv =====
// Bit-serial restoring divider for the interpolation step, one quotient bit
// per cycle. Depends on ttint_pkg for widths and the request/response types.
module ttint_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ttint_pkg::div_req_t req,
  output ttint_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(ttint_pkg::NUM_W + 1);

  logic [ttint_pkg::NUM_W-1:0] q_r, q_nxt;
  logic [ttint_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [ttint_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        done_r, done_nxt;
  logic [ttint_pkg::DEN_W:0]   trial;
  logic [ttint_pkg::DEN_W:0]   diff;
  logic                        ge;

  always_comb begin
    trial    = {rem_r, q_r[ttint_pkg::NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt   = req.num;
      rem_nxt = '0;
      den_nxt = req.den;
      cnt_nxt = CNT_W'(ttint_pkg::NUM_W);
    end else if (cnt_r != '0) begin
      q_nxt    = {q_r[ttint_pkg::NUM_W-2:0], ge};
      rem_nxt  = ge ? diff[ttint_pkg::DEN_W-1:0] : trial[ttint_pkg::DEN_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// ===== rtl/thermistor_table_interpolator.sv =====
// Thermistor table interpolator: turns a 10-bit converter code into a temperature in
// tenths of a degree, a cold/normal/hot class and an out-of-table flag. It handles one
// transaction at a time. Codes below or at the first breakpoint, or above the last one,
// skip the table walk and the division; other codes go through the table walk, which
// reads one ROM row per cycle, and then through the bit-serial divider, and take
// longer the further along the table the interval that holds the code lies. A finished
// result sits in the output register while the next transaction is accepted. Uses
// ttint_pkg and ttint_div.
module thermistor_table_interpolator #(
  parameter int TABLE_ENTRIES = ttint_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ttint_pkg::CODE_W-1:0]         in_adc_code,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ttint_pkg::TEMP_W-1:0]  out_temp_tenths,
  output logic [ttint_pkg::CLASS_W-1:0]        out_colour_class,
  output logic                                 out_out_of_range,
  input  logic                                 cfg_we,
  input  logic [ttint_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttint_pkg::TEMP_W-1:0]         cfg_wdata
);

  localparam int ROWS_CAP = (TABLE_ENTRIES > ttint_pkg::ROM_ROWS) ?
                            ttint_pkg::ROM_ROWS : TABLE_ENTRIES;
  localparam int ROWS     = (ROWS_CAP < 2) ? 2 : ROWS_CAP;
  localparam logic [ttint_pkg::IDX_W-1:0] LAST_IDX = ttint_pkg::IDX_W'(ROWS - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [ttint_pkg::CODE_W-1:0]        code_r, code_nxt;
  logic [ttint_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  logic signed [ttint_pkg::TEMP_W-1:0] base_r, base_nxt;
  logic signed [ttint_pkg::TEMP_W-1:0] temp_r, temp_nxt;
  logic                                flag_r, flag_nxt;
  logic signed [ttint_pkg::TEMP_W-1:0] cold_r, cold_nxt;
  logic signed [ttint_pkg::TEMP_W-1:0] hot_r, hot_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [ttint_pkg::TEMP_W-1:0] out_temp_r, out_temp_nxt;
  logic [ttint_pkg::CLASS_W-1:0]       out_class_r, out_class_nxt;
  logic                                out_flag_r, out_flag_nxt;

  logic [ttint_pkg::CODE_W-1:0]        lo_adc;
  logic [ttint_pkg::CODE_W-1:0]        hi_adc;
  logic [ttint_pkg::CODE_W-1:0]        first_adc;
  logic [ttint_pkg::CODE_W-1:0]        last_adc;
  logic [ttint_pkg::CODE_W-1:0]        span;
  logic [ttint_pkg::CODE_W-1:0]        off;
  logic                                hit;
  logic                                out_free;
  logic [ttint_pkg::CLASS_W-1:0]       cls;
  ttint_pkg::div_req_t                 div_req;
  ttint_pkg::div_rsp_t                 div_rsp;

  ttint_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    lo_adc    = ttint_pkg::rom_adc(idx_r);
    hi_adc    = ttint_pkg::rom_adc(idx_r + 1'b1);
    first_adc = ttint_pkg::rom_adc('0);
    last_adc  = ttint_pkg::rom_adc(LAST_IDX);
    span      = hi_adc - lo_adc;
    off       = code_r - lo_adc;
    hit       = (code_r <= hi_adc);
    out_free  = !out_valid_r || out_ready;

    if (temp_r < cold_r) begin
      cls = ttint_pkg::CLASS_COLD;
    end else if (temp_r < hot_r) begin
      cls = ttint_pkg::CLASS_NORMAL;
    end else begin
      cls = ttint_pkg::CLASS_HOT;
    end

    div_req.start = (state_r == ST_SCAN) && hit;
    div_req.num   = ttint_pkg::NUM_W'(off) * ttint_pkg::NUM_W'(ttint_pkg::STEP_TENTHS);
    div_req.den   = span;

    state_nxt     = state_r;
    code_nxt      = code_r;
    idx_nxt       = idx_r;
    base_nxt      = base_r;
    temp_nxt      = temp_r;
    flag_nxt      = flag_r;
    cold_nxt      = cold_r;
    hot_nxt       = hot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_temp_nxt  = out_temp_r;
    out_class_nxt = out_class_r;
    out_flag_nxt  = out_flag_r;

    if (cfg_we) begin
      case (cfg_index)
        ttint_pkg::REG_COLD_LIMIT: cold_nxt = cfg_wdata;
        ttint_pkg::REG_HOT_LIMIT:  hot_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          code_nxt  = in_adc_code;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        idx_nxt = '0;
        if (code_r < first_adc) begin
          temp_nxt  = ttint_pkg::rom_tenths('0);
          flag_nxt  = 1'b1;
          state_nxt = ST_OUT;
        end else if (code_r == first_adc) begin
          temp_nxt  = ttint_pkg::rom_tenths('0);
          flag_nxt  = 1'b0;
          state_nxt = ST_OUT;
        end else if (code_r > last_adc) begin
          temp_nxt  = ttint_pkg::rom_tenths(LAST_IDX);
          flag_nxt  = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          flag_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          base_nxt  = ttint_pkg::rom_tenths(idx_r);
          state_nxt = ST_DIV;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          temp_nxt  = base_r + $signed(ttint_pkg::TEMP_W'(div_rsp.quot));
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = temp_r;
          out_class_nxt = cls;
          out_flag_nxt  = flag_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cold_r      <= ttint_pkg::TEMP_W'(ttint_pkg::COLD_RESET);
      hot_r       <= ttint_pkg::TEMP_W'(ttint_pkg::HOT_RESET);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cold_r      <= cold_nxt;
      hot_r       <= hot_nxt;
    end
    code_r      <= code_nxt;
    idx_r       <= idx_nxt;
    base_r      <= base_nxt;
    temp_r      <= temp_nxt;
    flag_r      <= flag_nxt;
    out_temp_r  <= out_temp_nxt;
    out_class_r <= out_class_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_temp_tenths  = out_temp_r;
  assign out_colour_class = out_class_r;
  assign out_out_of_range = out_flag_r;

endmodule

// ===== rtl/ttint_chk.sv =====
// Port-level checker for the thermistor table interpolator, attached to the top
// level by the bind statement at the end. Depends on ttint_pkg for widths.
module ttint_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [ttint_pkg::TEMP_W-1:0] out_temp_tenths,
  input logic [ttint_pkg::CLASS_W-1:0]       out_colour_class,
  input logic                                out_out_of_range
);

  // The block takes one transaction and stays busy while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again in the cycle after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temp_tenths) &&
    $stable(out_colour_class) && $stable(out_out_of_range))
    else $error("stalled result changed or was dropped");

  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_colour_class != 2'd3)
    else $error("unused colour class code on output");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temp_tenths >= -12'sd400 && out_temp_tenths <= 12'sd1500)
    else $error("temperature outside the table range");

endmodule

bind thermistor_table_interpolator ttint_chk u_ttint_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_temp_tenths  (out_temp_tenths),
  .out_colour_class (out_colour_class),
  .out_out_of_range (out_out_of_range)
);
